// ===== sv/stm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

    localparam int unsigned SAMPLE_W      = 8;
    localparam int unsigned PHASE_W       = 32;
    localparam int unsigned COUNT_W       = 24;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned CFG_ADDR_W    = 1;
    localparam int unsigned TABLE_BITS_DEF = 10;

    localparam logic [PHASE_W-1:0] STEP_RESET = 32'd85704562;
    localparam logic [COUNT_W-1:0] LEN_RESET  = 24'd88200;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PHASE_STEP = 1'b0,
        REG_MIX_LENGTH = 1'b1
    } cfg_reg_t;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Q30 sine of an angle in the first quadrant, Taylor series to x^17 with
    // each term truncated, clamped to 1.0. Used only while building the table.
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] res;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        term = ((term * x2) >> 30) / 64'd6;   neg  = term;
        term = ((term * x2) >> 30) / 64'd20;  pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;  neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;  pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110; neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156; pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd210; neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd272; pos  = pos + term;
        if (neg >= pos)
        begin
            res = 64'd0;
        end
        else
        begin
            res = pos - neg;
            if (res > Q30_ONE)
            begin
                res = Q30_ONE;
            end
        end
        return res;
    endfunction

    // Tone table entry k for a table of 2^bits entries.
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned bits);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] j;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] mag;
        quarter = 64'd1 << (bits - 2);
        quad    = 64'(k) >> (bits - 2);
        rem     = 64'(k) & (quarter - 64'd1);
        j       = quad[0] ? (quarter - rem) : rem;
        if (j == quarter)
        begin
            s = Q30_ONE;
        end
        else
        begin
            s = sin_q30((j * TWO_PI_Q30) >> bits);
        end
        v = 64'd127 * s;
        if (quad < 64'd2)
        begin
            mag = 64'd128 + (v >> 30);
        end
        else
        begin
            mag = 64'd128 - ((v + Q30_ONE - 64'd1) >> 30);
        end
        return mag[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/sine_tone_mixer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel        Direction  Signals                         Payload
// s_axis         in         tvalid, tready, tdata[7:0]      sample_in
// m_axis         out        tvalid, tready, tdata[7:0]      sample_out
// cfg            in         cfg_we, cfg_addr, cfg_data      0: tone_phase_step, 1: mix_length
//
// One sample is taken every clock cycle while the output keeps draining; each
// result passes the first stage, where the registered tone table read lands
// beside the sample, and then the output register. Reset is asynchronous and
// active low and brings back the default step and mix length with the sample
// count and phase at zero. A stalled output holds the pipeline in place, and
// the input side keeps taking samples while the first stage has room or moves on.

module sine_tone_mixer_unit
    import stm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = TABLE_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]     s_axis_tdata,   // [7:0] sample_in
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic      [SAMPLE_W-1:0]     m_axis_tdata    // [7:0] sample_out
);

    logic                       accept;
    logic                       out_free;
    logic                       mix_now;
    logic [SINE_TABLE_BITS-1:0] tone_index;
    logic [SAMPLE_W-1:0]        tone;

    logic                       s1_valid_reg;
    logic                       s1_mix_reg;
    logic [SAMPLE_W-1:0]        s1_sample_reg;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic [SAMPLE_W-1:0]        out_data_next;
    logic [SAMPLE_W:0]          mix_sum;

    // The output register is free when empty or being drained this cycle; the
    // first stage can take a sample when it is empty or can move forward.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Count, phase accumulator and configuration registers. The mix decision
    // and the table index are taken from the state before this sample.
    stm_tone_gen #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_tone_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .advance  (accept),
        .mix      (mix_now),
        .index    (tone_index)
    );

    // Tone lookup lands in the first stage alongside the sample.
    stm_tone_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_tone_rom (
        .clk  (clk),
        .en   (accept),
        .addr (tone_index),
        .tone (tone)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mix_reg    <= mix_now;
            s1_sample_reg <= s_axis_tdata;
        end
    end

    // Average rounded down: keep the upper bits of the nine-bit sum.
    assign mix_sum       = {1'b0, s1_sample_reg} + {1'b0, tone};
    assign out_data_next = s1_mix_reg ? mix_sum[SAMPLE_W:1] : s1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // An accepted sample always occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample missing from first stage");

    // A sample in the first stage is never dropped while the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("first stage lost a stalled sample");

    // Samples past the mix window come out exactly as they went in.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free && !s1_mix_reg) |=>
            (m_axis_tvalid && m_axis_tdata == $past(s1_sample_reg)))
        else $error("passthrough sample altered");

endmodule

`default_nettype wire

// ===== sv/stm_tone_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stm_tone_rom
    import stm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = TABLE_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [SINE_TABLE_BITS-1:0] addr,
    output logic      [SAMPLE_W-1:0]        tone
);

    localparam int unsigned DEPTH = 1 << SINE_TABLE_BITS;

    typedef logic [SAMPLE_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int unsigned k = 0; k < DEPTH; k++)
        begin
            rom[k] = sine_entry(k, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam rom_t ROM_TABLE = build_rom();

    logic [SAMPLE_W-1:0] tone_reg;

    // Synchronous read port; the data holds while the stage is stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tone_reg <= ROM_TABLE[addr];
        end
    end

    assign tone = tone_reg;

endmodule

`default_nettype wire

// ===== sv/stm_tone_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stm_tone_gen
    import stm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = TABLE_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       advance,
    output logic                            mix,
    output logic      [SINE_TABLE_BITS-1:0] index
);

    logic [PHASE_W-1:0] step_reg;
    logic [COUNT_W-1:0] length_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    // The tone runs only while fewer than mix_length samples have been mixed.
    assign mix        = (count_reg < length_reg);
    assign index      = phase_reg[PHASE_W-1 -: SINE_TABLE_BITS];
    assign count_next = count_reg + COUNT_W'(1);
    assign phase_next = phase_reg + step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            length_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_PHASE_STEP: step_reg   <= cfg_data;
                REG_MIX_LENGTH: length_reg <= cfg_data[COUNT_W-1:0];
                default:        step_reg   <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
        end
        else if (advance && mix)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for sine_tone_mixer_unit.
//
// A sender process pushes unsigned 8-bit samples into the slave stream port.
// A receiver process takes the mixed samples from the master stream port.
// The testbench keeps its own copy of the phase accumulator, the sample count,
// the two registers and the sine table. For every accepted input transaction
// it works out the sample that must come out and queues it. The receiver
// compares each output transaction against the oldest queued sample.
//
// The directed part walks a short table of samples and register writes. It
// covers the first sample after reset, sample extremes, a zero mix length, a
// mix length equal to and below the current count, extreme phase steps with
// accumulator wrap, and a frozen phase. A random part follows, split into
// rounds with fresh register values between them.

module tb_top;

    import stm_pkg::*;

    localparam int          TONE_BITS   = TABLE_BITS_DEF;
    localparam int          TONE_SIZE   = 1 << TONE_BITS;
    localparam int          QUARTER     = TONE_SIZE / 4;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] TAU_Q30     = 64'd6746518852;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 120;
    localparam int          ROUNDS      = 8;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed table. For a sample row, fixed_result tells
    // whether the output is typed in here instead of taken from the predictor.
    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    target;
        logic [31:0] value;
        bit          fixed_result;
        logic [7:0]  result;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;   // [7:0] sample_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;        // [7:0] sample_out

    // Predictor state: the tone table, the two registers, count and phase.
    logic [7:0]  tone_lut [TONE_SIZE];
    logic [31:0] pred_step;
    logic [23:0] pred_len;
    logic [23:0] pred_count;
    logic [31:0] pred_phase;

    // Mixed samples that are owed by the block, oldest first.
    logic [7:0] expected_samples [$];

    dir_row_t dir_rows [$];
    int       err_count = 0;
    int       cycle_count;

    // Idle shaping. A burst flag turns off the random wait of that side. The
    // hold request asks the receiver for one long stall.
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_request = 1'b0;

    sine_tone_mixer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Q30 sine on the first quadrant. The odd powers of the Taylor series up
    // to x^17 are built one from the next, each truncated, and the result is
    // clamped to 1.0.
    function automatic logic [63:0] q30_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        x2    = (x * x) >> 30;
        term  = x;
        plus  = x;
        minus = 0;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                minus = minus + term;
            else
                plus = plus + term;
        end
        if (minus >= plus)
            return 64'd0;
        plus = plus - minus;
        return (plus > ONE_Q30) ? ONE_Q30 : plus;
    endfunction

    // The angle is folded into the first quadrant. The positive half-wave
    // rounds the scaled sine down, the negative half-wave rounds it up.
    task automatic build_tone_lut();
        int          quad;
        int          rem;
        logic [63:0] j;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < TONE_SIZE; k++)
        begin
            quad = k / QUARTER;
            rem  = k % QUARTER;
            j    = (quad % 2 == 1) ? 64'(QUARTER - rem) : 64'(rem);
            if (j == QUARTER)
                s = ONE_Q30;
            else
                s = q30_sine((j * TAU_Q30) >> TONE_BITS);
            v = 64'd127 * s;
            if (quad < 2)
                tone_lut[k] = 8'(64'd128 + (v >> 30));
            else
                tone_lut[k] = 8'(64'd128 - ((v + ONE_Q30 - 64'd1) >> 30));
        end
    endtask

    // Works out the output for one accepted sample and advances the tone.
    // Once the count has reached the mix length, samples pass through.
    function automatic logic [7:0] mix_predict(input logic [7:0] s);
        logic [7:0] tone;
        logic [8:0] total;
        if (pred_count < pred_len)
        begin
            tone       = tone_lut[pred_phase[31 -: TONE_BITS]];
            total      = {1'b0, s} + {1'b0, tone};
            pred_phase = pred_phase + pred_step;
            pred_count = pred_count + 24'd1;
            return total[8:1];
        end
        return s;
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        err_count++;
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one sample and returns at the edge where the transaction
    // completes. The expected output is queued at that same edge, well before
    // the result has passed the first stage and the output register.
    task automatic send_sample(input logic [7:0] s, input bit fixed_result,
                               input logic [7:0] result);
        int         gap;
        logic [7:0] predicted;
        gap = draw_gap(tx_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = mix_predict(s);
        expected_samples.push_back(fixed_result ? result : predicted);
    endtask

    // Register writes go in only while the block is idle: the input side is
    // quiet, every owed sample has come out and the pipeline had time to
    // settle.
    task automatic write_register(input cfg_reg_t target, input logic [31:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= target;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (target)
            REG_PHASE_STEP: pred_step = value;
            REG_MIX_LENGTH: pred_len  = value[23:0];
            default: ;
        endcase
    endtask

    // Receiver. It draws a wait before each transaction and, when asked,
    // holds tready low for a long stretch so the pipeline fills and the
    // block has to stall its input.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = draw_gap(rx_burst);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (expected_samples.size() == 0)
                flag_error($sformatf("unexpected sample_out %0d", m_axis_tdata));
            else if (m_axis_tdata !== expected_samples[0])
            begin
                flag_error($sformatf("sample_out %0d, expected %0d",
                                     m_axis_tdata, expected_samples[0]));
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0]  smp;
        logic [31:0] new_step;
        logic [23:0] new_len;
        int          items;

        build_tone_lut();
        pred_step  = 32'd85704562;
        pred_len   = 24'd88200;
        pred_count = '0;
        pred_phase = '0;

        // At phase zero the tone sits at mid-scale, 128, so the first mix
        // of a full-scale sample is (255 + 128) / 2 = 191.
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd255, 1'b1, 8'd191});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd0,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd128, 1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd1,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd254, 1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd127, 1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'h55,  1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'hAA,  1'b0, 8'd0});
        // With a zero mix length every sample passes through untouched.
        dir_rows.push_back('{ROW_WRITE,  REG_MIX_LENGTH, 32'd0,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd0,   1'b1, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd255, 1'b1, 8'd255});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'hAA,  1'b1, 8'hAA});
        // Eight samples were mixed; a length equal to the count, and then
        // one below it, must both pass samples through.
        dir_rows.push_back('{ROW_WRITE,  REG_MIX_LENGTH, 32'd8,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'h33,  1'b1, 8'h33});
        dir_rows.push_back('{ROW_WRITE,  REG_MIX_LENGTH, 32'd3,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'h5A,  1'b1, 8'h5A});
        // Largest step: the accumulator wraps on every sample. Four more
        // samples get mixed, picking up where the phase was left.
        dir_rows.push_back('{ROW_WRITE,  REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 8'd0});
        dir_rows.push_back('{ROW_WRITE,  REG_MIX_LENGTH, 32'd12,  1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd255, 1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd0,   1'b0, 8'd0});
        // A zero step freezes the phase, so the tone repeats.
        dir_rows.push_back('{ROW_WRITE,  REG_PHASE_STEP, 32'd0,   1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd17,  1'b0, 8'd0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd240, 1'b0, 8'd0});
        // The count has reached twelve, so mixing stops again.
        dir_rows.push_back('{ROW_SAMPLE, REG_PHASE_STEP, 32'd99,  1'b1, 8'd99});

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_register(dir_rows[i].target, dir_rows[i].value);
            else
                send_sample(dir_rows[i].value[7:0], dir_rows[i].fixed_result,
                            dir_rows[i].result);
        end

        // Random rounds. Each one starts with fresh register values taken
        // while the block is idle. The first round runs with no idling on
        // either side. The third keeps the sender busy while the receiver
        // stalls for a long stretch.
        for (int round_idx = 0; round_idx < ROUNDS; round_idx++)
        begin
            case ($urandom_range(0, 5))
                0: new_step = 32'd0;
                1: new_step = 32'hFFFF_FFFF;
                2: new_step = 32'h8000_0000;
                default: new_step = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: new_len = 24'd0;
                1: new_len = 24'hFF_FFFF;
                2: new_len = (pred_count > 0) ? 24'($urandom_range(0, pred_count - 1)) : '0;
                default: new_len = pred_count + 24'($urandom_range(1, 160));
            endcase
            write_register(REG_PHASE_STEP, new_step);
            write_register(REG_MIX_LENGTH, {8'd0, new_len});

            tx_burst = (round_idx == 0 || round_idx == 2) || ($urandom_range(0, 3) == 0);
            rx_burst = (round_idx == 0) || ($urandom_range(0, 3) == 0);
            if (round_idx == 2)
                hold_request = 1'b1;

            items = $urandom_range(100, 112);
            for (int n = 0; n < items; n++)
            begin
                smp = draw_sample();
                send_sample(smp, 1'b0, 8'd0);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/stm_pkg.sv
sv/stm_tone_rom.sv
sv/stm_tone_gen.sv
sv/sine_tone_mixer_unit.sv
tb/tb_top.sv
